### rtl/rasp_pkg.sv
`timescale 1ns / 1ps
// Package for the radial alpha sprite pixel unit: field widths, fixed-point
// constants, pipeline stage map and the register and mode codes. No dependencies.
package rasp_pkg;

    // Field widths of the ports.
    localparam int SIDE_W  = 11;
    localparam int PIX_W   = 10;
    localparam int MODE_W  = 2;
    localparam int ALPHA_W = 8;
    localparam int ADDR_W  = 22;

    // The pixel index carried down the pipe; the byte address is this times four.
    localparam int PIXIDX_W = ADDR_W - 2;

    // Largest side code the register can hold.
    localparam int SIDE_MAX_CODE = (2 ** SIDE_W) - 1;
    localparam int MAX_SIDE_DEFAULT = 1024;

    // Distance arithmetic widths.
    localparam int DELTA_W = SIDE_W + 1;          // 2x - s, signed
    localparam int SQ_W    = 2 * SIDE_W;          // dx^2, s^2
    localparam int SUM_W   = SQ_W + 1;            // dx^2 + dy^2, 2*s^2
    localparam int REM_W   = SUM_W + 1;           // shifted divider remainder
    localparam int QUOT_W  = 32;                  // Q0.32 r^2 below one
    localparam int RAD_W   = 34;                  // radicand, even width
    localparam int ROOT_W  = 17;                  // Q1.16 r, up to one
    localparam int SQRT_REM_W = 21;
    localparam int FRAC_W  = 16;
    localparam int PROD_W  = 2 * ROOT_W;

    localparam logic [RAD_W-1:0]   RAD_ONE  = RAD_W'(64'h1_0000_0000);
    localparam logic [ROOT_W-1:0]  ONE_Q16  = ROOT_W'(32'h1_0000);
    localparam logic [ALPHA_W-1:0] FULL_ALPHA = 8'd255;

    // Register reset values.
    localparam logic [SIDE_W-1:0] SIDE_RESET = 11'd64;
    localparam logic [MODE_W-1:0] MODE_RESET = 2'd0;

    // Pipeline stage map.
    localparam int DIV_STEPS   = QUOT_W;
    localparam int SQRT_STEPS  = RAD_W / 2;
    localparam int POWER_STEPS = 9;
    localparam int STG_DELTA   = 0;
    localparam int STG_SQUARE  = 1;
    localparam int STG_SUM     = 2;
    localparam int DIV_END     = STG_SUM + DIV_STEPS;
    localparam int SQRT_END    = DIV_END + SQRT_STEPS;
    localparam int STG_TERM    = SQRT_END + 1;
    localparam int POW_END     = STG_TERM + POWER_STEPS;
    localparam int STG_OUT     = POW_END + 1;
    localparam int NUM_STAGES  = STG_OUT + 1;

    // Configuration register indexes.
    typedef enum logic [0:0] {
        CFG_SIDE_LENGTH  = 1'b0,
        CFG_FALLOFF_MODE = 1'b1
    } cfg_index_t;

    // Falloff modes; the unused code behaves as full alpha.
    typedef enum logic [MODE_W-1:0] {
        MODE_LINEAR = 2'd0,
        MODE_POWER  = 2'd1,
        MODE_FLAT   = 2'd2
    } falloff_mode_t;

endpackage

### rtl/radial_alpha_sprite_pixel_unit.sv
`timescale 1ns / 1ps
// Radial alpha sprite pixel unit: pixel coordinate in, alpha byte and RGBA byte
// address out, through a register pipeline. Depends on rasp_pkg.
//
//  Channel  | Handshake                    | Payload
//  ---------+------------------------------+---------------------------------
//  pixel    | pixel_valid / pixel_ready    | pixel_x, pixel_y
//  result   | result_valid / result_ready  | alpha_value, byte_address
//  cfg      | cfg_valid / cfg_ready        | cfg_index, cfg_data
//
// One pixel beat is taken per clock unless the pipe is stalled; its result beat is
// offered from the last of 63 register stages: three for offsets, squares
// and sum, 32 one-bit divider stages, 17 one-bit square root stages, ten for one
// minus r and its powers, and the output stage.
// Reset clears all stage valid bits and loads side 64 and linear falloff.
// A result beat that is not taken stalls the whole pipe, input included, for
// as long as it waits; nothing is lost or repeated. Configuration beats are
// always taken.
module radial_alpha_sprite_pixel_unit #(
    parameter int MAX_SIDE = rasp_pkg::MAX_SIDE_DEFAULT
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [0:0]                     cfg_index,
    input  logic [rasp_pkg::SIDE_W-1:0]    cfg_data,
    input  logic                           pixel_valid,
    output logic                           pixel_ready,
    input  logic [rasp_pkg::PIX_W-1:0]     pixel_x,
    input  logic [rasp_pkg::PIX_W-1:0]     pixel_y,
    output logic                           result_valid,
    input  logic                           result_ready,
    output logic [rasp_pkg::ALPHA_W-1:0]   alpha_value,
    output logic [rasp_pkg::ADDR_W-1:0]    byte_address
);

    localparam int SIDE_W     = rasp_pkg::SIDE_W;
    localparam int NUM_STAGES = rasp_pkg::NUM_STAGES;
    localparam int DIV_STEPS  = rasp_pkg::DIV_STEPS;
    localparam int SQRT_STEPS = rasp_pkg::SQRT_STEPS;
    localparam int POW_STEPS  = rasp_pkg::POWER_STEPS;
    localparam int SQ_W       = rasp_pkg::SQ_W;
    localparam int SUM_W      = rasp_pkg::SUM_W;
    localparam int REM_W      = rasp_pkg::REM_W;
    localparam int QUOT_W     = rasp_pkg::QUOT_W;
    localparam int RAD_W      = rasp_pkg::RAD_W;
    localparam int ROOT_W     = rasp_pkg::ROOT_W;
    localparam int SREM_W     = rasp_pkg::SQRT_REM_W;
    localparam int FRAC_W     = rasp_pkg::FRAC_W;
    localparam int PROD_W     = rasp_pkg::PROD_W;
    localparam int DELTA_W    = rasp_pkg::DELTA_W;
    localparam int PIXIDX_W   = rasp_pkg::PIXIDX_W;
    localparam int MODE_W     = rasp_pkg::MODE_W;
    localparam int ALPHA_W    = rasp_pkg::ALPHA_W;

    // The side register cannot exceed its own code range, so the cap stops there.
    localparam logic [SIDE_W-1:0] SIDE_CAP = (MAX_SIDE > rasp_pkg::SIDE_MAX_CODE) ?
        SIDE_W'(rasp_pkg::SIDE_MAX_CODE) : SIDE_W'(MAX_SIDE);

    // Configuration registers.
    logic [SIDE_W-1:0] side_length_reg;
    logic [MODE_W-1:0] falloff_mode_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_length_reg  <= rasp_pkg::SIDE_RESET;
            falloff_mode_reg <= rasp_pkg::MODE_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                rasp_pkg::CFG_SIDE_LENGTH:  side_length_reg  <= cfg_data;
                rasp_pkg::CFG_FALLOFF_MODE: falloff_mode_reg <= cfg_data[MODE_W-1:0];
                default: ;
            endcase
        end
    end

    // Whole-pipe advance: everything moves unless a finished result is held.
    logic adv;
    assign adv         = !result_valid || result_ready;
    assign pixel_ready = adv;

    // Stage valid bits and the sideband that rides with every stage.
    logic [NUM_STAGES-1:0] valid_reg;
    logic [NUM_STAGES-1:0] valid_next;
    logic [MODE_W-1:0]     mode_reg   [NUM_STAGES];
    logic [PIXIDX_W-1:0]   pixidx_reg [NUM_STAGES];

    assign valid_next = {valid_reg[NUM_STAGES-2:0], pixel_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (adv)
        begin
            valid_reg <= valid_next;
        end
    end

    // Effective side and the linear pixel index, formed at the input.
    logic [SIDE_W-1:0]      side_eff;
    logic [PIXIDX_W+1:0]    pixidx_full;
    logic [PIXIDX_W-1:0]    pixidx_next;

    always_comb
    begin
        side_eff = side_length_reg;
        if (side_eff == '0)
        begin
            side_eff = SIDE_W'(1);
        end
        else if (side_eff > SIDE_CAP)
        begin
            side_eff = SIDE_CAP;
        end
        pixidx_full = (PIXIDX_W+2)'(side_eff) * (PIXIDX_W+2)'(pixel_y)
                    + (PIXIDX_W+2)'(pixel_x);
        pixidx_next = pixidx_full[PIXIDX_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            mode_reg[0]   <= falloff_mode_reg;
            pixidx_reg[0] <= pixidx_next;
            for (int i = 1; i < NUM_STAGES; i++)
            begin
                mode_reg[i]   <= mode_reg[i-1];
                pixidx_reg[i] <= pixidx_reg[i-1];
            end
        end
    end

    // Stage 0: offsets from the center, doubled so they stay integers.
    logic signed [DELTA_W-1:0] dx_reg, dy_reg;
    logic signed [DELTA_W-1:0] dx_next, dy_next;
    logic [SIDE_W-1:0]         side_reg;

    assign dx_next = $signed({1'b0, pixel_x, 1'b0}) - $signed({1'b0, side_eff});
    assign dy_next = $signed({1'b0, pixel_y, 1'b0}) - $signed({1'b0, side_eff});

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dx_reg   <= dx_next;
            dy_reg   <= dy_next;
            side_reg <= side_eff;
        end
    end

    // Stage 1: the three squares.
    logic signed [2*DELTA_W-1:0] dx_sq, dy_sq;
    logic [SQ_W-1:0]             side_sq;
    logic [SQ_W-1:0]             sqx_reg, sqy_reg, ssq_reg;

    assign dx_sq   = dx_reg * dx_reg;
    assign dy_sq   = dy_reg * dy_reg;
    assign side_sq = SQ_W'(side_reg) * SQ_W'(side_reg);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sqx_reg <= dx_sq[SQ_W-1:0];
            sqy_reg <= dy_sq[SQ_W-1:0];
            ssq_reg <= side_sq;
        end
    end

    // Divider lanes; entry 0 is the sum stage, entry k the k-th quotient bit.
    logic [SUM_W-1:0]  rem_reg  [DIV_STEPS+1];
    logic [SUM_W-1:0]  den_reg  [DIV_STEPS+1];
    logic [QUOT_W-1:0] quot_reg [DIV_STEPS+1];
    logic              sat_reg  [DIV_STEPS+1];
    logic [SUM_W-1:0]  rem_next [DIV_STEPS+1];
    logic [SUM_W-1:0]  den_next [DIV_STEPS+1];
    logic [QUOT_W-1:0] quot_next[DIV_STEPS+1];
    logic              sat_next [DIV_STEPS+1];

    // Stage 2: squared distance against its corner value; at or past it r is one.
    always_comb
    begin
        rem_next[0]  = {1'b0, sqx_reg} + {1'b0, sqy_reg};
        den_next[0]  = {ssq_reg, 1'b0};
        sat_next[0]  = rem_next[0] >= den_next[0];
        quot_next[0] = '0;
    end

    // Restoring division of sum * 2^32 by the corner value, one bit a stage.
    for (genvar k = 1; k <= DIV_STEPS; k++)
    begin : g_div
        logic [REM_W-1:0] rem_shift;
        logic             take;

        always_comb
        begin
            rem_shift    = {rem_reg[k-1], 1'b0};
            take         = rem_shift >= {1'b0, den_reg[k-1]};
            rem_next[k]  = take ? SUM_W'(rem_shift - {1'b0, den_reg[k-1]})
                                : rem_shift[SUM_W-1:0];
            den_next[k]  = den_reg[k-1];
            sat_next[k]  = sat_reg[k-1];
            quot_next[k] = {quot_reg[k-1][QUOT_W-2:0], take};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k <= DIV_STEPS; k++)
            begin
                rem_reg[k]  <= rem_next[k];
                den_reg[k]  <= den_next[k];
                quot_reg[k] <= quot_next[k];
                sat_reg[k]  <= sat_next[k];
            end
        end
    end

    // Square root lanes, two radicand bits and one root bit a stage.
    logic [RAD_W-1:0]  rad_reg   [SQRT_STEPS];
    logic [SREM_W-1:0] srem_reg  [SQRT_STEPS];
    logic [ROOT_W-1:0] root_reg  [SQRT_STEPS];
    logic [RAD_W-1:0]  rad_next  [SQRT_STEPS];
    logic [SREM_W-1:0] srem_next [SQRT_STEPS];
    logic [ROOT_W-1:0] root_next [SQRT_STEPS];

    for (genvar j = 0; j < SQRT_STEPS; j++)
    begin : g_sqrt
        localparam int PAIR_LSB = 2 * (SQRT_STEPS - 1 - j);
        logic [RAD_W-1:0]  rad_in;
        logic [SREM_W-1:0] srem_in;
        logic [ROOT_W-1:0] root_in;
        logic [SREM_W-1:0] srem_shift;
        logic [SREM_W-1:0] trial;
        logic              take;

        always_comb
        begin
            if (j == 0)
            begin
                // A saturated distance enters as exactly one in Q2.32.
                rad_in  = sat_reg[DIV_STEPS] ? rasp_pkg::RAD_ONE
                                             : RAD_W'(quot_reg[DIV_STEPS]);
                srem_in = '0;
                root_in = '0;
            end
            else
            begin
                rad_in  = rad_reg[(j == 0) ? 0 : j-1];
                srem_in = srem_reg[(j == 0) ? 0 : j-1];
                root_in = root_reg[(j == 0) ? 0 : j-1];
            end
            srem_shift   = {srem_in[SREM_W-3:0], rad_in[PAIR_LSB +: 2]};
            trial        = SREM_W'({root_in, 2'b01});
            take         = srem_shift >= trial;
            srem_next[j] = take ? (srem_shift - trial) : srem_shift;
            root_next[j] = {root_in[ROOT_W-2:0], take};
            rad_next[j]  = rad_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int j = 0; j < SQRT_STEPS; j++)
            begin
                rad_reg[j]  <= rad_next[j];
                srem_reg[j] <= srem_next[j];
                root_reg[j] <= root_next[j];
            end
        end
    end

    // Power lanes; entry 0 is the one-minus-r stage, entry n holds t^(n+1).
    logic [ROOT_W-1:0] term_reg  [POW_STEPS+1];
    logic [ROOT_W-1:0] pow_reg   [POW_STEPS+1];
    logic [ROOT_W-1:0] term_next [POW_STEPS+1];
    logic [ROOT_W-1:0] pow_next  [POW_STEPS+1];
    logic [ROOT_W-1:0] root_cap;

    always_comb
    begin
        root_cap = root_reg[SQRT_STEPS-1];
        if (root_cap > rasp_pkg::ONE_Q16)
        begin
            root_cap = rasp_pkg::ONE_Q16;
        end
        term_next[0] = rasp_pkg::ONE_Q16 - root_cap;
        pow_next[0]  = term_next[0];
    end

    // Each stage multiplies once by t and drops sixteen fraction bits.
    for (genvar n = 1; n <= POW_STEPS; n++)
    begin : g_pow
        logic [PROD_W-1:0] prod;

        always_comb
        begin
            prod         = PROD_W'(pow_reg[n-1]) * PROD_W'(term_reg[n-1]);
            pow_next[n]  = prod[FRAC_W +: ROOT_W];
            term_next[n] = term_reg[n-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int n = 0; n <= POW_STEPS; n++)
            begin
                term_reg[n] <= term_next[n];
                pow_reg[n]  <= pow_next[n];
            end
        end
    end

    // Output stage: scale by 255 and select by mode.
    logic [ROOT_W-1:0]          scale_in;
    logic [ROOT_W+ALPHA_W-1:0]  scaled;
    logic [ALPHA_W-1:0]         alpha_next;
    logic [ALPHA_W-1:0]         alpha_reg;

    always_comb
    begin
        scale_in   = term_reg[POW_STEPS];
        alpha_next = rasp_pkg::FULL_ALPHA;
        if (mode_reg[rasp_pkg::POW_END] == rasp_pkg::MODE_POWER)
        begin
            scale_in = pow_reg[POW_STEPS];
        end
        scaled = (ROOT_W+ALPHA_W)'(rasp_pkg::FULL_ALPHA) * (ROOT_W+ALPHA_W)'(scale_in);
        case (mode_reg[rasp_pkg::POW_END])
            rasp_pkg::MODE_LINEAR,
            rasp_pkg::MODE_POWER: alpha_next = scaled[FRAC_W +: ALPHA_W];
            default:              alpha_next = rasp_pkg::FULL_ALPHA;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            alpha_reg <= alpha_next;
        end
    end

    assign result_valid = valid_reg[rasp_pkg::STG_OUT];
    assign alpha_value  = alpha_reg;
    assign byte_address = {pixidx_reg[rasp_pkg::STG_OUT], 2'b00};

    // A held result freezes every stage valid bit.
    assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(valid_reg))
        else $error("pipeline valid bits moved during a stall");

    // An accepted pixel beat lands in the first stage.
    assert property (@(posedge clk) disable iff (!rst_n)
        (pixel_valid && pixel_ready) |=> valid_reg[rasp_pkg::STG_DELTA])
        else $error("accepted pixel beat missing from the first stage");

    // Without saturation the divider remainder stays below the divisor.
    assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg[rasp_pkg::DIV_END] && !sat_reg[DIV_STEPS])
            |-> (rem_reg[DIV_STEPS] < den_reg[DIV_STEPS]))
        else $error("divider remainder out of range");

    // The normalized distance never exceeds one.
    assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[rasp_pkg::SQRT_END] |-> (root_reg[SQRT_STEPS-1] <= rasp_pkg::ONE_Q16))
        else $error("square root above one");

    // Flat and spare modes always give full alpha.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && mode_reg[rasp_pkg::STG_OUT] != rasp_pkg::MODE_LINEAR
                      && mode_reg[rasp_pkg::STG_OUT] != rasp_pkg::MODE_POWER)
            |-> (alpha_value == rasp_pkg::FULL_ALPHA))
        else $error("flat mode result is not full alpha");

endmodule
